### rtl/srs_pkg.sv
// shared types and constants for the searchable record stack
// depends on nothing; imported by the top level and the testbench
package srs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int CODE_W      = 16;
    localparam int SALARY_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int OPCODE_W    = 2;
    localparam int OUT_CNT_W   = 7;
    localparam int REC_W       = CODE_W + SALARY_W;

    localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [SALARY_W-1:0] salary;
    } t_record;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH
    } t_state;

endpackage

### rtl/searchable_record_stack.sv
// top level of the searchable record stack: control sequencer and record ram
// depends on srs_pkg and srs_ram
//
// usage
//   a request (opcode, code, salary) is taken at a rising edge where start is
//   high and busy is low. each request gives exactly one result, shown for one
//   cycle with o_valid high; the receiver cannot hold it off.
//   opcodes: push, pop, search by code; the unused opcode changes nothing and
//   reports success with the current count.
// latency and throughput
//   push, unused opcode, and pop or search on an empty stack: result in the
//   cycle after the request, busy stays low, so one request per cycle.
//   pop: one ram read, result taken from the ram data in the pop state,
//   busy for one cycle. search: the ram is read one entry per cycle from
//   the top down, busy while the walk runs; the walk ends at the first match
//   or at the bottom entry, so at most the count of entries is examined. the
//   single read port of the record ram sets this walk rate.
// reset
//   i_rst_n low clears the count, the sequencer and the result strobe; the
//   record ram is not cleared, only entries below the count are ever read.
// stalls
//   none on the result side; results are never held or repeated.
module searchable_record_stack
    import srs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [CODE_W-1:0]    i_entry_code,
    input  logic [SALARY_W-1:0]  i_entry_salary,
    output logic                 o_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [CODE_W-1:0]    o_found_code,
    output logic [SALARY_W-1:0]  o_found_salary,
    output logic [OUT_CNT_W-1:0] o_stack_count
);

    // sequencer state
    t_state              r_state,  n_state;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [ADDR_W-1:0]   r_idx,    n_idx;
    logic [CODE_W-1:0]   r_key,    n_key;

    // result register
    logic                r_valid,  n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CODE_W-1:0]   r_code,   n_code;
    logic [SALARY_W-1:0] r_salary, n_salary;

    // ram side
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    t_record             ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    t_record             ram_rd_data;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    logic [ADDR_W-1:0]   top_addr;

    assign accept   = start && (r_state == S_IDLE);
    assign is_full  = (r_count == CNT_W'(STACK_DEPTH));
    assign is_empty = (r_count == '0);
    // address of the top record, meaningful only when not empty
    assign top_addr = ADDR_W'(r_count - CNT_W'(1));

    srs_ram #(
        .WIDTH (REC_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_status <= n_status;
        r_code   <= n_code;
        r_salary <= n_salary;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_code      = r_code;
        n_salary    = r_salary;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_count[ADDR_W-1:0];
        ram_wr_data = '{code: i_entry_code, salary: i_entry_salary};
        ram_rd_en   = 1'b0;
        ram_rd_addr = top_addr;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_code   = '0;
                    n_salary = '0;
                    case (i_opcode)
                        OP_PUSH: begin
                            n_valid = 1'b1;
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                // write lands before any later read can be issued
                                ram_wr_en = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                ram_rd_en = 1'b1;
                                n_count   = r_count - CNT_W'(1);
                                n_state   = S_POP;
                            end
                        end
                        OP_SEARCH: begin
                            if (is_empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                // start the walk at the top record
                                ram_rd_en = 1'b1;
                                n_idx     = top_addr;
                                n_key     = i_entry_code;
                                n_state   = S_SEARCH;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_code   = ram_rd_data.code;
                n_salary = ram_rd_data.salary;
                n_state  = S_IDLE;
            end
            S_SEARCH: begin
                // ram_rd_data holds the entry at r_idx
                if (ram_rd_data.code == r_key) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_code   = ram_rd_data.code;
                    n_salary = ram_rd_data.salary;
                    n_state  = S_IDLE;
                end else if (r_idx == '0) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_state  = S_IDLE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_idx - ADDR_W'(1);
                    n_idx       = r_idx - ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found_code   = r_code;
    assign o_found_salary = r_salary;
    // count after the operation, masked to the port width
    assign o_stack_count  = OUT_CNT_W'(r_count);

endmodule

### rtl/srs_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module srs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for searchable_record_stack: directed then random requests
// depends on srs_pkg and the searchable_record_stack rtl; a shadow stack predicts each result
module tb_top;
    import srs_pkg::*;

    // the fourth opcode has no name in the package; the block must treat it as a no-op
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 800;
    // slowest legal gap between handshakes is a full-depth search plus a sender gap;
    // the limit is that taken many times over
    localparam int WATCHDOG_LIMIT  = 5000;
    // longest search walks the whole stack, so the wait at the end grows with the depth
    localparam int DRAIN_CYCLES    = STACK_DEPTH + 20;

    // modes of the random part: push-heavy, pop-heavy, balanced
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [CODE_W-1:0]   code;
        logic [SALARY_W-1:0] salary;
        int unsigned         gap;
    } t_request;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [CODE_W-1:0]    code;
        logic [SALARY_W-1:0]  salary;
        logic [OUT_CNT_W-1:0] count;
    } t_outcome;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    logic [OPCODE_W-1:0]  i_opcode       = '0;
    logic [CODE_W-1:0]    i_entry_code   = '0;
    logic [SALARY_W-1:0]  i_entry_salary = '0;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [CODE_W-1:0]    o_found_code;
    logic [SALARY_W-1:0]  o_found_salary;
    logic [OUT_CNT_W-1:0] o_stack_count;

    searchable_record_stack dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_entry_code   (i_entry_code),
        .i_entry_salary (i_entry_salary),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found_code   (o_found_code),
        .o_found_salary (o_found_salary),
        .o_stack_count  (o_stack_count)
    );

    // requests waiting to be driven, and results still owed by the block
    t_request pending_reqs[$];
    t_outcome expected_outcomes[$];

    // shadow copy of the stack, updated as each request is accepted
    t_record     shadow_records [STACK_DEPTH];
    int unsigned shadow_depth = 0;

    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;

    // driver look-ahead: the next request and the gap still to wait before it
    logic        have_next = 1'b0;
    t_request    next_req;
    int unsigned wait_left = 0;

    // a few codes reused often so that searches hit, and duplicates occur
    logic [CODE_W-1:0] code_pool [8] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h5555,
                                         16'hAAAA, 16'h00FF, 16'h8000, 16'h0001};

    // applies one request to the shadow stack and gives the result it must produce
    function automatic t_outcome apply_stack_op(input logic [OPCODE_W-1:0] op,
                                                input logic [CODE_W-1:0]   code,
                                                input logic [SALARY_W-1:0] salary);
        t_outcome res;
        bit       hit;
        res.status = ST_OK;
        res.code   = '0;
        res.salary = '0;
        hit        = 1'b0;
        case (op)
            OP_PUSH: begin
                if (shadow_depth >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_records[shadow_depth].code   = code;
                    shadow_records[shadow_depth].salary = salary;
                    shadow_depth++;
                end
            end
            OP_POP: begin
                if (shadow_depth == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_depth--;
                    res.code   = shadow_records[shadow_depth].code;
                    res.salary = shadow_records[shadow_depth].salary;
                end
            end
            OP_SEARCH: begin
                if (shadow_depth == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // top down, first match wins, so the newest duplicate is returned
                    for (int i = int'(shadow_depth) - 1; i >= 0; i--) begin
                        if (!hit && shadow_records[i].code == code) begin
                            hit        = 1'b1;
                            res.code   = shadow_records[i].code;
                            res.salary = shadow_records[i].salary;
                        end
                    end
                    if (!hit) begin
                        res.status = ST_NOTFOUND;
                    end
                end
            end
            default: ;  // unused opcode leaves everything as it is
        endcase
        res.count = OUT_CNT_W'(shadow_depth);
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(0, 9) < 7) begin
            return code_pool[$urandom_range(0, 7)];
        end
        return CODE_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic queue_request(input logic [OPCODE_W-1:0] op,
                                 input logic [CODE_W-1:0]   code,
                                 input logic [SALARY_W-1:0] salary,
                                 input int unsigned         gap);
        t_request req;
        req.op     = op;
        req.code   = code;
        req.salary = salary;
        req.gap    = gap;
        pending_reqs.push_back(req);
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // synchronous reset, released once after start-up and never asserted again
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: presents one request at a time, holds it while busy, then waits its gap
    always @(posedge i_clk) begin : drive_requests
        logic take;
        logic next_start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = start && !busy;
            if (take) begin
                expected_outcomes.push_back(
                    apply_stack_op(i_opcode, i_entry_code, i_entry_salary));
            end
            // a request not yet taken stays on the ports unchanged
            next_start = start && !take;
            if (!next_start) begin
                if (!have_next && pending_reqs.size() != 0) begin
                    next_req  = pending_reqs.pop_front();
                    wait_left = next_req.gap;
                    have_next = 1'b1;
                end
                if (have_next) begin
                    if (wait_left == 0) begin
                        i_opcode       <= next_req.op;
                        i_entry_code   <= next_req.code;
                        i_entry_salary <= next_req.salary;
                        next_start     = 1'b1;
                        have_next      = 1'b0;
                    end else begin
                        wait_left--;
                    end
                end
            end
            start <= next_start;
        end
    end

    // monitor: every strobed result is matched against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (expected_outcomes.size() == 0) begin
                $error("result with no request outstanding: status %0d", o_status);
                error_count++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_found_code !== want.code) begin
                    $error("found_code: expected %h, got %h", want.code, o_found_code);
                    error_count++;
                end
                if (o_found_salary !== want.salary) begin
                    $error("found_salary: expected %h, got %h", want.salary, o_found_salary);
                    error_count++;
                end
                if (o_stack_count !== want.count) begin
                    $error("stack_count: expected %0d, got %0d", want.count, o_stack_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long with neither a request taken nor a result shown means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned seg_len;
        int unsigned roll;
        int unsigned mode;
        int unsigned push_lim;
        int unsigned pop_lim;
        int unsigned search_lim;
        bit          first;
        bit          calm;
        logic [OPCODE_W-1:0]  op;
        logic [SALARY_W-1:0]  salary;

        // directed: empty cases first, then extremes, duplicates and a miss, then drain
        // past empty, refill with two, search, and pop back to empty for a last search
        queue_request(OP_POP,    16'h0000, 32'h0000_0000, $urandom_range(0, 6));
        queue_request(OP_SEARCH, 16'hFFFF, 32'h0000_0000, $urandom_range(0, 6));
        queue_request(OP_UNUSED, 16'h0000, 32'h0000_0000, $urandom_range(0, 6));
        queue_request(OP_PUSH,   16'h0000, 32'h0000_0000, $urandom_range(0, 6));
        queue_request(OP_PUSH,   16'hFFFF, 32'hFFFF_FFFF, 0);
        queue_request(OP_PUSH,   16'h1234, 32'h0000_0001, 0);
        queue_request(OP_PUSH,   16'h1234, 32'h8000_0000, $urandom_range(0, 6));
        queue_request(OP_SEARCH, 16'h1234, 32'hFFFF_FFFF, 0);
        queue_request(OP_SEARCH, 16'h0000, 32'h0000_0000, 0);
        queue_request(OP_SEARCH, 16'h5555, 32'h1234_5678, $urandom_range(0, 6));
        queue_request(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 0);
        queue_request(OP_POP,    16'hFFFF, 32'hFFFF_FFFF, 0);
        queue_request(OP_SEARCH, 16'h1234, 32'h0000_0000, $urandom_range(0, 6));
        queue_request(OP_POP,    16'h0000, 32'h0000_0000, 0);
        queue_request(OP_POP,    16'h0000, 32'h0000_0000, 0);
        queue_request(OP_POP,    16'h0000, 32'h0000_0000, $urandom_range(0, 6));
        queue_request(OP_POP,    16'h0000, 32'h0000_0000, 0);
        queue_request(OP_PUSH,   16'hAAAA, 32'h5555_5555, 0);
        queue_request(OP_PUSH,   16'h5555, 32'hAAAA_AAAA, 0);
        queue_request(OP_SEARCH, 16'hAAAA, 32'h0000_0000, $urandom_range(0, 6));
        queue_request(OP_POP,    16'h0000, 32'h0000_0000, 0);
        queue_request(OP_POP,    16'h0000, 32'h0000_0000, 0);
        queue_request(OP_SEARCH, 16'h5555, 32'h0000_0000, 0);

        // random: segments of one mode each; the first fills well past full so that
        // full pushes and full-depth searches occur, some segments run with no gaps
        n     = 0;
        first = 1'b1;
        while (n < RANDOM_REQUESTS) begin
            mode    = first ? MODE_FILL : $urandom_range(MODE_FILL, MODE_MIXED);
            seg_len = first ? 120 : $urandom_range(20, 120);
            calm    = ($urandom_range(0, 3) == 0);
            first   = 1'b0;
            case (mode)
                MODE_FILL: begin
                    push_lim = 75; pop_lim = 83; search_lim = 95;
                end
                MODE_DRAIN: begin
                    push_lim = 10; pop_lim = 80; search_lim = 95;
                end
                default: begin
                    push_lim = 40; pop_lim = 70; search_lim = 95;
                end
            endcase
            for (int k = 0; k < int'(seg_len) && n < RANDOM_REQUESTS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < push_lim)        op = OP_PUSH;
                else if (roll < pop_lim)    op = OP_POP;
                else if (roll < search_lim) op = OP_SEARCH;
                else                        op = OP_UNUSED;
                case ($urandom_range(0, 9))
                    0:       salary = 32'h0000_0000;
                    1:       salary = 32'hFFFF_FFFF;
                    default: salary = $urandom();
                endcase
                queue_request(op, pick_code(), salary, calm ? 0 : $urandom_range(0, 6));
                n++;
            end
        end

        // all requests taken and all results seen, then a quiet spell for stray strobes
        while (pending_reqs.size() != 0 || have_next || start
               || expected_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_outcomes.size() != 0) begin
            $error("%0d results never arrived", expected_outcomes.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/searchable_record_stack.sv
tb/tb_top.sv
